[hdl/cpe_pkg.sv]
// ============================================================================
// cpe_pkg - shared types, constants and arithmetic helpers
// Fixed-point format, opcodes, controller command bundle and the saturating
// add, subtract and rounded-product functions of the recurrence datapath.
// ============================================================================
package cpe_pkg;

    // Fixed-point format and sizes
    localparam int FRAC_BITS = 30;
    localparam int MAX_ORDER = 64;
    localparam int POINT_W   = 32;
    localparam int ORDER_W   = 7;
    localparam int OPCODE_W  = 2;
    localparam int DATA_W    = 64;
    localparam int VHALF_W   = DATA_W / 2;
    localparam int PP_W      = POINT_W + VHALF_W;
    localparam int SUM_W     = PP_W + VHALF_W + 1;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_VALUE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DERIV1 = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DERIV2 = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam data_t ONE      = data_t'(1) <<< FRAC_BITS;

    // Value with overflow flag
    typedef struct packed {
        logic  ovf;
        data_t val;
    } sat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic zero_order;
        logic mul;
        logic rnd;
        logic add;
        logic out_load;
    } cmd_t;

    // Saturating signed add
    function automatic sat_t sat_add(input data_t a, input data_t b);
        logic [DATA_W:0] s;
        sat_t            r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.ovf = (s[DATA_W] != s[DATA_W-1]);
        if (r.ovf)
            r.val = s[DATA_W] ? DATA_MIN : DATA_MAX;
        else
            r.val = s[DATA_W-1:0];
        return r;
    endfunction

    // Saturating signed subtract
    function automatic sat_t sat_sub(input data_t a, input data_t b);
        logic [DATA_W:0] s;
        sat_t            r;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        r.ovf = (s[DATA_W] != s[DATA_W-1]);
        if (r.ovf)
            r.val = s[DATA_W] ? DATA_MIN : DATA_MAX;
        else
            r.val = s[DATA_W-1:0];
        return r;
    endfunction

    // Combine the two partial products, round half away from zero, saturate
    function automatic sat_t fx_round(input logic [PP_W-1:0] pp_lo,
                                      input logic [PP_W-1:0] pp_hi,
                                      input logic            neg);
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  mag;
        logic [SUM_W-1:0]  limit;
        logic [DATA_W-1:0] mlo;
        sat_t              r;
        sum = {1'b0, pp_hi, {VHALF_W{1'b0}}}
            + {{(SUM_W-PP_W){1'b0}}, pp_lo}
            + (SUM_W'(1) << (FRAC_BITS - 1));
        mag   = sum >> FRAC_BITS;
        limit = neg ? (SUM_W'(1) << (DATA_W - 1))
                    : ((SUM_W'(1) << (DATA_W - 1)) - SUM_W'(1));
        mlo   = mag[DATA_W-1:0];
        r.ovf = (mag > limit);
        if (r.ovf)
            r.val = neg ? DATA_MIN : DATA_MAX;
        else
            r.val = neg ? data_t'(DATA_W'(0) - mlo) : data_t'(mlo);
        return r;
    endfunction

endpackage

[hdl/cpe_datapath.sv]
// ============================================================================
// cpe_datapath - recurrence registers, multiplier and adders
// Holds x and the T, T', T'' pairs, runs one step in three phases
// (multiply, round, sum) on command and keeps the output register.
// ============================================================================
module cpe_datapath (
    input  logic                            clk,
    input  cpe_pkg::cmd_t                   cmd,
    input  logic signed [cpe_pkg::POINT_W-1:0]  point,
    input  logic [cpe_pkg::OPCODE_W-1:0]    opcode,
    output logic signed [cpe_pkg::DATA_W-1:0]   result,
    output logic                            saturated
);

    // Clamped point and its magnitude
    cpe_pkg::data_t                     xs;
    cpe_pkg::data_t                     xc;
    logic [cpe_pkg::POINT_W-1:0]        x_clamp;
    logic [cpe_pkg::POINT_W-1:0]        ux_reg;
    logic                               xneg_reg;
    logic [cpe_pkg::OPCODE_W-1:0]       opcode_reg;

    // Recurrence state: lane 0 value, lane 1 first, lane 2 second derivative
    cpe_pkg::data_t                     prev_reg [3];
    cpe_pkg::data_t                     cur_reg  [3];
    cpe_pkg::data_t                     cur_next [3];

    // Multiplier and rounding pipeline
    logic [cpe_pkg::DATA_W-1:0]         uv       [3];
    logic [cpe_pkg::PP_W-1:0]           pp_lo_next [3];
    logic [cpe_pkg::PP_W-1:0]           pp_hi_next [3];
    logic [cpe_pkg::PP_W-1:0]           pp_lo_reg  [3];
    logic [cpe_pkg::PP_W-1:0]           pp_hi_reg  [3];
    logic                               pneg_reg   [3];
    cpe_pkg::sat_t                      rnd        [3];
    cpe_pkg::data_t                     prod_reg   [3];
    logic                               sat_reg;

    // Step sums
    cpe_pkg::sat_t t_dbl, t_new;
    cpe_pkg::sat_t d_pdbl, d_tdbl, d_sum, d_new;
    cpe_pkg::sat_t h_pdbl, h_d2, h_d4, h_sum, h_new;
    logic          step_ovf;
    logic          rnd_ovf;

    logic signed [cpe_pkg::DATA_W-1:0]  result_next;
    logic                               saturated_next;
    logic signed [cpe_pkg::DATA_W-1:0]  result_reg;
    logic                               saturated_reg;

    // Clamp x to [-1,1]
    always_comb
    begin
        xs = {{(cpe_pkg::DATA_W-cpe_pkg::POINT_W){point[cpe_pkg::POINT_W-1]}}, point};
        if (xs > cpe_pkg::ONE)
            xc = cpe_pkg::ONE;
        else if (xs < -cpe_pkg::ONE)
            xc = -cpe_pkg::ONE;
        else
            xc = xs;
        x_clamp = xc[cpe_pkg::POINT_W-1:0];
    end

    // Partial products of |x| with both halves of |v|
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            uv[i] = cur_reg[i][cpe_pkg::DATA_W-1] ? (cpe_pkg::DATA_W'(0) - cur_reg[i])
                                                  : cur_reg[i];
            pp_lo_next[i] = cpe_pkg::PP_W'(ux_reg)
                          * cpe_pkg::PP_W'(uv[i][cpe_pkg::VHALF_W-1:0]);
            pp_hi_next[i] = cpe_pkg::PP_W'(ux_reg)
                          * cpe_pkg::PP_W'(uv[i][cpe_pkg::DATA_W-1:cpe_pkg::VHALF_W]);
        end
    end

    // Round and saturate the products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rnd[i] = cpe_pkg::fx_round(pp_lo_reg[i], pp_hi_reg[i], pneg_reg[i]);
        rnd_ovf = rnd[0].ovf | rnd[1].ovf | rnd[2].ovf;
    end

    // Form the next terms of the three recurrences
    always_comb
    begin
        t_dbl  = cpe_pkg::sat_add(prod_reg[0], prod_reg[0]);
        t_new  = cpe_pkg::sat_sub(t_dbl.val, prev_reg[0]);

        d_pdbl = cpe_pkg::sat_add(prod_reg[1], prod_reg[1]);
        d_tdbl = cpe_pkg::sat_add(cur_reg[0], cur_reg[0]);
        d_sum  = cpe_pkg::sat_add(d_pdbl.val, d_tdbl.val);
        d_new  = cpe_pkg::sat_sub(d_sum.val, prev_reg[1]);

        h_pdbl = cpe_pkg::sat_add(prod_reg[2], prod_reg[2]);
        h_d2   = cpe_pkg::sat_add(cur_reg[1], cur_reg[1]);
        h_d4   = cpe_pkg::sat_add(h_d2.val, h_d2.val);
        h_sum  = cpe_pkg::sat_add(h_pdbl.val, h_d4.val);
        h_new  = cpe_pkg::sat_sub(h_sum.val, prev_reg[2]);

        cur_next[0] = t_new.val;
        cur_next[1] = d_new.val;
        cur_next[2] = h_new.val;

        step_ovf = t_dbl.ovf | t_new.ovf
                 | d_pdbl.ovf | d_tdbl.ovf | d_sum.ovf | d_new.ovf
                 | h_pdbl.ovf | h_d2.ovf | h_d4.ovf | h_sum.ovf | h_new.ovf;
    end

    // Pick the requested quantity
    always_comb
    begin
        case (opcode_reg)
            cpe_pkg::OP_VALUE:
            begin
                result_next    = cur_reg[0];
                saturated_next = sat_reg;
            end
            cpe_pkg::OP_DERIV1:
            begin
                result_next    = cur_reg[1];
                saturated_next = sat_reg;
            end
            cpe_pkg::OP_DERIV2:
            begin
                result_next    = cur_reg[2];
                saturated_next = sat_reg;
            end
            default:
            begin
                result_next    = '0;
                saturated_next = 1'b0;
            end
        endcase
    end

    // Load, step and hold the datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            ux_reg     <= x_clamp[cpe_pkg::POINT_W-1] ? (cpe_pkg::POINT_W'(0) - x_clamp)
                                                      : x_clamp;
            xneg_reg   <= x_clamp[cpe_pkg::POINT_W-1];
            opcode_reg <= opcode;
            sat_reg    <= 1'b0;
            prev_reg[0] <= cpe_pkg::ONE;
            prev_reg[1] <= '0;
            prev_reg[2] <= '0;
            if (cmd.zero_order) begin
                cur_reg[0] <= cpe_pkg::ONE;
                cur_reg[1] <= '0;
            end
            else begin
                cur_reg[0] <= xc;
                cur_reg[1] <= cpe_pkg::ONE;
            end
            cur_reg[2] <= '0;
        end
        else if (cmd.add) begin
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= cur_reg[i];
                cur_reg[i]  <= cur_next[i];
            end
            sat_reg <= sat_reg | step_ovf;
        end
        else if (cmd.rnd) begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= rnd[i].val;
            sat_reg <= sat_reg | rnd_ovf;
        end

        if (cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                pp_lo_reg[i] <= pp_lo_next[i];
                pp_hi_reg[i] <= pp_hi_next[i];
                pneg_reg[i]  <= xneg_reg ^ cur_reg[i][cpe_pkg::DATA_W-1];
            end
        end

        if (cmd.out_load) begin
            result_reg    <= result_next;
            saturated_reg <= saturated_next;
        end
    end

    assign result    = result_reg;
    assign saturated = saturated_reg;

endmodule

[hdl/cpe_ctrl.sv]
// ============================================================================
// cpe_ctrl - sequencer for the recurrence
// Accepts a request, counts recurrence steps through the multiply, round and
// sum phases, then hands the result to the output register.
// ============================================================================
module cpe_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic [cpe_pkg::ORDER_W-1:0]    poly_order,
    input  logic                           rsp_stall,
    output logic                           req_stall,
    output logic                           rsp_valid,
    output cpe_pkg::cmd_t                  cmd
);

    localparam int CNT_W = $clog2(cpe_pkg::MAX_ORDER + 1);
    localparam int ORD_W = (CNT_W > cpe_pkg::ORDER_W) ? CNT_W : cpe_pkg::ORDER_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [ORD_W-1:0] ord_ext;
    logic [CNT_W-1:0] n_eff;

    // Limit the order to the largest supported
    always_comb
    begin
        ord_ext = ORD_W'(poly_order);
        if (ord_ext > ORD_W'(cpe_pkg::MAX_ORDER))
            n_eff = CNT_W'(cpe_pkg::MAX_ORDER);
        else
            n_eff = ord_ext[CNT_W-1:0];
    end

    // Sequence one request
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid) begin
                    cmd.load       = 1'b1;
                    cmd.zero_order = (n_eff == '0);
                    if (n_eff < CNT_W'(2)) begin
                        state_next = S_FIN;
                    end
                    else begin
                        cnt_next   = n_eff - CNT_W'(1);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = (cnt_reg == CNT_W'(1)) ? S_FIN : S_MUL;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !rsp_stall) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Multiply phase always advances to the round phase
    a_mul_to_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_RND))
        else $error("multiply phase not followed by round phase");

    // Step counter never runs dry inside the loop
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (cnt_reg != '0))
        else $error("sum phase with zero steps left");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("output register overwritten while stalled");

    // An accepted request starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request left block idle");

endmodule

[hdl/chebyshev_poly_eval_with_derivatives.sv]
// ============================================================================
// chebyshev_poly_eval_with_derivatives - T_n(x), T_n'(x), T_n''(x) evaluator
// Runs the value, first and second derivative recurrences together up to
// the order and returns the quantity chosen by the opcode, saturated.
// ============================================================================
// Steps: n-1 recurrence steps for order n of 2 or more (n limited to 64), none
//   for order 0 or 1; each step takes a multiply, a round and a sum phase through
//   one set of three 32x32 multiplier pairs.
// Throughput: a new request is taken only after the last one's result is loaded;
//   a new request is taken while the previous result waits in the output register.
// Reset: rst_n clears the sequencer and output valid; no clearing pass.
module chebyshev_poly_eval_with_derivatives (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic signed [cpe_pkg::POINT_W-1:0] point,
    input  logic [cpe_pkg::ORDER_W-1:0]        poly_order,
    input  logic [cpe_pkg::OPCODE_W-1:0]       opcode,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [cpe_pkg::DATA_W-1:0]  result,
    output logic                               saturated
);

    cpe_pkg::cmd_t cmd;

    // Sequencer
    cpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .poly_order (poly_order),
        .rsp_stall  (rsp_stall),
        .req_stall  (req_stall),
        .rsp_valid  (rsp_valid),
        .cmd        (cmd)
    );

    // Arithmetic
    cpe_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .point      (point),
        .opcode     (opcode),
        .result     (result),
        .saturated  (saturated)
    );

endmodule
